>>> hdl/asfc_pkg.sv
// asfc_pkg: shared types, constants and the crc-8 byte update for the
// angle sensor frame checker; no dependencies
`default_nettype none

package asfc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AngleW  = 14;
  localparam int unsigned AngHiW  = AngleW - ByteW;

  localparam logic [ByteW-1:0] CRC_POLY = 8'h2F;
  localparam logic [ByteW-1:0] CRC_INIT = 8'hFF;

  localparam logic [PosW-1:0] POS_ANGLE_LO = 3'd0;
  localparam logic [PosW-1:0] POS_ANGLE_HI = 3'd1;
  localparam logic [PosW-1:0] POS_RSV_A    = 3'd2;
  localparam logic [PosW-1:0] POS_RSV_B    = 3'd3;
  localparam logic [PosW-1:0] POS_GAIN     = 3'd4;
  localparam logic [PosW-1:0] POS_RSV_C    = 3'd5;
  localparam logic [PosW-1:0] POS_MARKER   = 3'd6;
  localparam logic [PosW-1:0] POS_CRC      = 3'd7;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_RESERVED = 3'd1;
  localparam logic [StatusW-1:0] ST_GAIN     = 3'd2;
  localparam logic [StatusW-1:0] ST_CRC      = 3'd3;
  localparam logic [StatusW-1:0] ST_MARKER   = 3'd4;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AngleW-1:0]  angle;
  } asfc_result_t;

  // msb first, no reflection
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                  input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/asfc_frame_track.sv
// asfc_frame_track: frame position, running crc and check flags for one
// reply frame; depends on asfc_pkg
`default_nettype none

module asfc_frame_track (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic [asfc_pkg::ByteW-1:0] rx_byte,
  input  wire logic                       frame_start,
  output logic                            is_last,
  output asfc_pkg::asfc_result_t          res
);
  import asfc_pkg::*;

  logic [PosW-1:0]   pos_r, pos_nxt, pos;
  logic [ByteW-1:0]  crc_r, crc_nxt, crc_base;
  logic [ByteW-1:0]  ang_lo_r, ang_lo_nxt;
  logic [AngHiW-1:0] ang_hi_r, ang_hi_nxt;
  logic              rsv_r, rsv_nxt;
  logic              gain_zero_r, gain_zero_nxt;
  logic [1:0]        marker_r, marker_nxt;
  logic              first;
  logic [ByteW-1:0]  crc_calc;

  assign pos      = frame_start ? POS_ANGLE_LO : pos_r;
  assign first    = (pos == POS_ANGLE_LO);
  assign is_last  = (pos == POS_CRC);
  assign crc_base = first ? CRC_INIT : crc_r;
  assign crc_calc = ~crc_r;

  always_comb begin
    pos_nxt       = pos + PosW'(1);
    crc_nxt       = is_last ? crc_r : crc8_update(crc_base, rx_byte);
    ang_lo_nxt    = first ? rx_byte : ang_lo_r;
    ang_hi_nxt    = first ? '0 : ang_hi_r;
    rsv_nxt       = first ? 1'b0 : rsv_r;
    gain_zero_nxt = first ? 1'b0 : gain_zero_r;
    marker_nxt    = first ? 2'b00 : marker_r;
    case (pos)
      POS_ANGLE_HI: ang_hi_nxt = rx_byte[AngHiW-1:0];
      POS_RSV_A, POS_RSV_B, POS_RSV_C: begin
        if (rx_byte != '0) begin
          rsv_nxt = 1'b1;
        end
      end
      POS_GAIN:   gain_zero_nxt = (rx_byte == '0);
      POS_MARKER: marker_nxt = rx_byte[ByteW-1:ByteW-2];
      default: ;
    endcase
  end

  always_comb begin
    res.angle = '0;
    if (rsv_r) begin
      res.status = ST_RESERVED;
    end else if (gain_zero_r) begin
      res.status = ST_GAIN;
    end else if (crc_calc != rx_byte) begin
      res.status = ST_CRC;
    end else if (marker_r != 2'b00) begin
      res.status = ST_MARKER;
    end else begin
      res.status = ST_OK;
      res.angle  = {ang_hi_r, ang_lo_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_ANGLE_LO;
      crc_r       <= CRC_INIT;
      ang_lo_r    <= '0;
      ang_hi_r    <= '0;
      rsv_r       <= 1'b0;
      gain_zero_r <= 1'b0;
      marker_r    <= 2'b00;
    end else if (adv) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      ang_lo_r    <= ang_lo_nxt;
      ang_hi_r    <= ang_hi_nxt;
      rsv_r       <= rsv_nxt;
      gain_zero_r <= gain_zero_nxt;
      marker_r    <= marker_nxt;
    end
  end

  a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_last |=> pos_r == POS_ANGLE_LO)
    else $error("position did not wrap after crc byte");

  a_step_position: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !frame_start |=> pos_r == PosW'($past(pos_r) + PosW'(1)))
    else $error("position did not step by one");

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && frame_start |=> pos_r == POS_ANGLE_HI && crc_r != '0 || pos_r == POS_ANGLE_HI)
    else $error("frame start did not restart at byte one");

  a_angle_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res.angle != '0 |-> res.status == ST_OK)
    else $error("angle given with error status");

endmodule

`default_nettype wire

>>> hdl/angle_sensor_frame_checker_unit.sv
// angle_sensor_frame_checker_unit: top level with input and result registers
// around the frame tracker; depends on asfc_pkg and asfc_frame_track
//
// usage
//   in_ channel carries one reply byte per request, with in_frame_start marking
//   byte 0 of a frame; without it bytes take the next position, wrapping
//   after byte 7 so back-to-back frames need no mark.
//   out_ channel gives one request (out_status, out_angle) per crc byte,
//   i.e. after bytes 0 to 7 of a frame; bytes 0 to 6 give nothing.
//   out_angle is the 14-bit angle when out_status is ok and zero otherwise.
// timing
//   one byte per cycle sustained unless a crc byte waits for the result
//   register; the byte register feeds the crc update and checks, whose
//   outcome lands in the result register. a crc byte moves from the byte
//   register into the result register once the result register is free.
// reset and stall
//   synchronous active-low reset empties both registers and restarts the
//   frame at byte 0 with the crc preset.
//   while out_ready is low a pending result holds; bytes that give no result
//   keep flowing, and a crc byte waits in the byte register.
`default_nettype none

module angle_sensor_frame_checker_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [asfc_pkg::ByteW-1:0]   in_rx_byte,
  input  wire logic                         in_frame_start,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [asfc_pkg::StatusW-1:0]      out_status,
  output logic [asfc_pkg::AngleW-1:0]       out_angle
);
  import asfc_pkg::*;

  logic             s0_valid_r;
  logic [ByteW-1:0] s0_byte_r;
  logic             s0_start_r;
  logic             out_valid_r;
  asfc_result_t     out_res_r;
  asfc_result_t     res;
  logic             is_last;
  logic             out_free;
  logic             s0_adv;

  assign out_free = !out_valid_r || out_ready;
  assign s0_adv   = s0_valid_r && (!is_last || out_free);
  assign in_ready = !s0_valid_r || s0_adv;

  asfc_frame_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (s0_adv),
    .rx_byte     (s0_byte_r),
    .frame_start (s0_start_r),
    .is_last     (is_last),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s0_byte_r  <= in_rx_byte;
      s0_start_r <= in_frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s0_adv && is_last;
    end
    if (out_free && s0_adv && is_last) begin
      out_res_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_res_r.status;
  assign out_angle  = out_res_r.angle;

  a_blocked_crc_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && !s0_adv |-> is_last && out_valid_r && !out_ready && !in_ready)
    else $error("byte stage stalled without a pending result");

  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !(s0_adv && is_last) |=> !out_valid_r)
    else $error("result request repeated");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv && is_last |=> out_valid_r)
    else $error("crc byte gave no result");

endmodule

`default_nettype wire

>>> sim/asfc_checker.sv
// asfc_checker: watches both channels of the angle sensor frame checker,
// predicts one verdict per crc byte and compares it field by field
// depends on asfc_pkg for the result type, positions and status codes
`timescale 1ns / 1ps

module asfc_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic [asfc_pkg::ByteW-1:0]   in_rx_byte,
  input  wire logic                         in_frame_start,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic [asfc_pkg::StatusW-1:0] out_status,
  input  wire logic [asfc_pkg::AngleW-1:0]  out_angle,
  output int                                error_count,
  output int                                verdicts_pending
);

  import asfc_pkg::*;

  logic [PosW-1:0]   next_pos;
  logic [ByteW-1:0]  crc_reg;
  logic [ByteW-1:0]  ang_lo;
  logic [AngHiW-1:0] ang_hi;
  logic              rsv_dirty;
  logic              gain_zero;
  logic [1:0]        marker;
  asfc_result_t      frame_verdict_q[$];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic predict_frame_byte(input logic [ByteW-1:0] b, input logic start);
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] calc;
    asfc_result_t     verdict;
    pos = start ? POS_ANGLE_LO : next_pos;
    if (pos == POS_ANGLE_LO) begin
      crc_reg   = CRC_INIT;
      rsv_dirty = 1'b0;
      gain_zero = 1'b0;
      marker    = '0;
      ang_hi    = '0;
      ang_lo    = b;
    end
    // bit-serial msb-first crc over bytes 0 to 6
    if (pos != POS_CRC) begin
      for (int i = ByteW - 1; i >= 0; i--) begin
        crc_reg = {crc_reg[ByteW-2:0], 1'b0} ^
                  ((crc_reg[ByteW-1] ^ b[i]) ? CRC_POLY : '0);
      end
    end
    case (pos)
      POS_ANGLE_HI: ang_hi = b[AngHiW-1:0];
      POS_RSV_A, POS_RSV_B, POS_RSV_C: begin
        if (b != '0) begin
          rsv_dirty = 1'b1;
        end
      end
      POS_GAIN: gain_zero = (b == '0);
      POS_MARKER: marker = b[ByteW-1 -: 2];
      POS_CRC: begin
        calc = ~crc_reg;
        verdict.angle = '0;
        if (rsv_dirty) begin
          verdict.status = ST_RESERVED;
        end else if (gain_zero) begin
          verdict.status = ST_GAIN;
        end else if (calc != b) begin
          verdict.status = ST_CRC;
        end else if (marker != '0) begin
          verdict.status = ST_MARKER;
        end else begin
          verdict.status = ST_OK;
          verdict.angle  = {ang_hi, ang_lo};
        end
        frame_verdict_q.push_back(verdict);
      end
      default: ;
    endcase
    next_pos = pos + PosW'(1);
  endtask

  always @(posedge clk) begin
    asfc_result_t want;
    if (!rst_n) begin
      next_pos  = POS_ANGLE_LO;
      crc_reg   = CRC_INIT;
      ang_lo    = '0;
      ang_hi    = '0;
      rsv_dirty = 1'b0;
      gain_zero = 1'b0;
      marker    = '0;
      frame_verdict_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (frame_verdict_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending (status %0d angle %0d)",
                                    out_status, out_angle));
        end else begin
          want = frame_verdict_q.pop_front();
          if (out_status != want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          end
          if (out_angle != want.angle) begin
            report_mismatch($sformatf("angle got %0d want %0d", out_angle, want.angle));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_frame_byte(in_rx_byte, in_frame_start);
      end
    end
    verdicts_pending <= frame_verdict_q.size();
  end

endmodule

>>> sim/tb_angle_sensor_frame_checker_unit.sv
// tb_angle_sensor_frame_checker_unit: drives reply bytes and result backpressure
// into the angle sensor frame checker and gives the verdict
// depends on asfc_pkg, angle_sensor_frame_checker_unit and asfc_checker
`timescale 1ns / 1ps

module tb_angle_sensor_frame_checker_unit;

  import asfc_pkg::*;

  localparam int RandomBytes   = 1000;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 16;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic [ByteW-1:0]   in_rx_byte     = '0;
  logic               in_frame_start = 1'b0;
  logic               out_ready      = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [StatusW-1:0] out_status;
  logic [AngleW-1:0]  out_angle;

  int   error_count;
  int   verdicts_pending;
  int   send_idle_pct = 32;
  int   recv_idle_pct = 86;
  logic hold_req      = 1'b0;
  logic hold_taken    = 1'b0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;
  int   bytes_sent    = 0;
  logic frame_aligned = 1'b1;

  always #5 clk = ~clk;

  angle_sensor_frame_checker_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_angle      (out_angle)
  );

  asfc_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_angle        (out_angle),
    .error_count      (error_count),
    .verdicts_pending (verdicts_pending)
  );

  // result side backpressure, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HoldCycles;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [ByteW-1:0] sealed_crc(input logic [7:0][ByteW-1:0] f);
    logic [ByteW-1:0] c;
    c = CRC_INIT;
    for (int i = 0; i < 7; i++) begin
      c ^= f[i];
      repeat (ByteW) c = c[ByteW-1] ? ({c[ByteW-2:0], 1'b0} ^ CRC_POLY) : {c[ByteW-2:0], 1'b0};
    end
    return ~c;
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // sends the first nbytes of a frame; restart_at > 0 raises a start mark mid-frame
  task automatic send_frame(input logic [7:0][ByteW-1:0] f, input logic start,
                            input int nbytes, input int restart_at);
    for (int i = 0; i < nbytes; i++) begin
      send_byte(f[i], (i == 0) ? start : (i == restart_at));
    end
  endtask

  task automatic send_random_frame();
    logic [7:0][ByteW-1:0] f;
    logic                  start;
    int                    nbytes;
    int                    restart_at;
    if ($urandom_range(9) == 0) begin
      for (int i = 0; i < 8; i++) f[i] = ByteW'($urandom);
    end else begin
      f[0] = ByteW'($urandom);
      f[1] = ByteW'($urandom);
      f[2] = '0;
      f[3] = '0;
      f[4] = ByteW'($urandom_range(255, 1));
      f[5] = '0;
      f[6] = {2'b00, 6'($urandom)};
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: f[POS_RSV_A] = ByteW'($urandom_range(255, 1));
          1: f[POS_RSV_B] = ByteW'($urandom_range(255, 1));
          default: f[POS_RSV_C] = ByteW'($urandom_range(255, 1));
        endcase
      end
      if ($urandom_range(9) == 0) f[POS_GAIN] = '0;
      if ($urandom_range(9) == 0) f[POS_MARKER][7:6] = 2'($urandom_range(3, 1));
      f[POS_CRC] = sealed_crc(f);
      if ($urandom_range(9) == 0) f[POS_CRC] ^= ByteW'($urandom_range(255, 1));
    end
    start      = !frame_aligned || ($urandom_range(1) == 1);
    nbytes     = 8;
    restart_at = 0;
    case ($urandom_range(19))
      0: nbytes = $urandom_range(7, 1);
      1: restart_at = $urandom_range(7, 1);
      default: ;
    endcase
    send_frame(f, start, nbytes, restart_at);
    frame_aligned = (nbytes == 8) && (restart_at == 0);
  endtask

  initial begin
    logic [7:0][ByteW-1:0] f;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // full angle and ok status
    f = {8'h00, 8'h3F, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
    f[POS_CRC] = sealed_crc(f);
    send_frame(f, 1'b1, 8, 0);
    // back-to-back without start mark, reserved nonzero
    f = {8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h80, 8'h00, 8'h00};
    f[POS_CRC] = sealed_crc(f);
    send_frame(f, 1'b0, 8, 0);
    // partial frame dropped by a new start, then zero gain over a bad marker
    f = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h34, 8'h12};
    send_frame(f, 1'b1, 3, 0);
    f = {8'h00, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 8'h01};
    f[POS_CRC] = sealed_crc(f);
    send_frame(f, 1'b1, 8, 0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      while (bytes_sent < (phase + 1) * RandomBytes / 3 + 27) send_random_frame();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/asfc_pkg.sv
hdl/asfc_frame_track.sv
hdl/angle_sensor_frame_checker_unit.sv
sim/asfc_checker.sv
sim/tb_angle_sensor_frame_checker_unit.sv
